/* rtl/saes_pkg.sv */
// Shared types, S-box tables and GF(16) helpers for the simplified AES cipher.
// No dependencies; imported by saes_core, simplified_aes_cipher and saes_checker.
package saes_pkg;

  typedef logic [3:0]  nibble_t;
  typedef logic [7:0]  byte_t;
  typedef logic [15:0] block_t;

  localparam logic [2:0] ADDR_CIPHER_KEY = 3'd0;

  localparam byte_t RCON1 = 8'h80;
  localparam byte_t RCON2 = 8'h30;

  localparam nibble_t SBOX_FWD [16] = '{
    4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
    4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
  };

  localparam nibble_t SBOX_INV [16] = '{
    4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
    4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
  };

  // multiply by x modulo x^4+x+1
  function automatic nibble_t gf_xtime(nibble_t n);
    return {n[2:0], 1'b0} ^ (n[3] ? 4'h3 : 4'h0);
  endfunction

  function automatic nibble_t gf_mul2(nibble_t n);
    return gf_xtime(n);
  endfunction

  function automatic nibble_t gf_mul4(nibble_t n);
    return gf_xtime(gf_xtime(n));
  endfunction

  function automatic nibble_t gf_mul9(nibble_t n);
    return gf_xtime(gf_xtime(gf_xtime(n))) ^ n;
  endfunction

  function automatic block_t sub_nibbles(block_t v, logic inv);
    block_t r;
    for (int i = 0; i < 4; i++) begin
      r[4*i +: 4] = inv ? SBOX_INV[v[4*i +: 4]] : SBOX_FWD[v[4*i +: 4]];
    end
    return r;
  endfunction

  // swap second and fourth nibble
  function automatic block_t shift_rows(block_t v);
    return {v[15:12], v[3:0], v[7:4], v[11:8]};
  endfunction

  function automatic block_t mix_columns(block_t v, logic inv);
    nibble_t n0, n1, n2, n3;
    nibble_t m0, m1, m2, m3;
    n0 = v[15:12];
    n1 = v[11:8];
    n2 = v[7:4];
    n3 = v[3:0];
    if (inv) begin
      m0 = gf_mul9(n0) ^ gf_mul2(n1);
      m1 = gf_mul2(n0) ^ gf_mul9(n1);
      m2 = gf_mul9(n2) ^ gf_mul2(n3);
      m3 = gf_mul2(n2) ^ gf_mul9(n3);
    end else begin
      m0 = n0 ^ gf_mul4(n1);
      m1 = gf_mul4(n0) ^ n1;
      m2 = n2 ^ gf_mul4(n3);
      m3 = gf_mul4(n2) ^ n3;
    end
    return {m0, m1, m2, m3};
  endfunction

  function automatic byte_t key_g(byte_t w, byte_t rcon);
    return {SBOX_FWD[w[3:0]], SBOX_FWD[w[7:4]]} ^ rcon;
  endfunction

endpackage

/* rtl/simplified_aes_cipher.sv */
// Simplified AES block cipher, 16-bit block and key. Top level with APB key register.
// Depends on saes_pkg and saes_core.
//
// A word is taken at every clock edge where start is high; busy never rises, so one
// word per cycle is sustained. Each word passes an input register, one combinational
// pass of both cipher rounds and the key schedule, and the result register. done and
// result_block are loaded by that result register; done is high for exactly one cycle
// per word. The receiver cannot stall the output. APB writes to addresses 0 to 3 all
// set the key. The key sits at APB address 0 and must only change while no word is in flight.
module simplified_aes_cipher (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             start,
  output logic             busy,
  input  logic             cmd,
  input  saes_pkg::block_t data_block,
  output logic             done,
  output saes_pkg::block_t result_block
);
  import saes_pkg::*;

  block_t cipher_key;
  logic   in_valid;
  logic   in_cmd;
  block_t in_block;
  block_t core_out;
  logic   key_hit;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign key_hit = (paddr == ADDR_CIPHER_KEY);
  assign prdata  = key_hit ? {16'h0000, cipher_key} : 32'h0000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      cipher_key <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_cmd   <= cmd;
      in_block <= data_block;
    end
    result_block <= core_out;
  end

  saes_core u_core (
    .dec  (in_cmd),
    .key  (cipher_key),
    .din  (in_block),
    .dout (core_out)
  );

endmodule

/* rtl/saes_core.sv */
// Combinational two-round cipher datapath with round-key expansion.
// Depends on saes_pkg.
module saes_core (
  input  logic            dec,
  input  saes_pkg::block_t key,
  input  saes_pkg::block_t din,
  output saes_pkg::block_t dout
);
  import saes_pkg::*;

  byte_t  w2, w3, w4, w5;
  block_t k1, k2;
  block_t e0, e1, e2;
  block_t d0, d1, d2;

  always_comb begin
    w2 = key[15:8] ^ key_g(key[7:0], RCON1);
    w3 = w2 ^ key[7:0];
    w4 = w2 ^ key_g(w3, RCON2);
    w5 = w4 ^ w3;
    k1 = {w2, w3};
    k2 = {w4, w5};
  end

  always_comb begin
    e0 = shift_rows(sub_nibbles(din ^ key, 1'b0));
    e1 = mix_columns(e0, 1'b0) ^ k1;
    e2 = shift_rows(sub_nibbles(e1, 1'b0)) ^ k2;

    d0 = sub_nibbles(shift_rows(din ^ k2), 1'b1) ^ k1;
    d1 = mix_columns(d0, 1'b1);
    d2 = sub_nibbles(shift_rows(d1), 1'b1) ^ key;

    dout = dec ? d2 : e2;
  end

endmodule

/* rtl/saes_checker.sv */
// Port-level checks on simplified_aes_cipher timing and determinism.
// Depends on saes_pkg; bound to simplified_aes_cipher below.
module saes_checker (
  input logic             clk,
  input logic             rst,
  input logic             psel,
  input logic             penable,
  input logic             pwrite,
  input logic             pready,
  input logic             start,
  input logic             busy,
  input logic             cmd,
  input saes_pkg::block_t data_block,
  input logic             done,
  input saes_pkg::block_t result_block
);
  import saes_pkg::*;

  logic acc;
  logic cfg_we;

  assign acc    = start && !busy;
  assign cfg_we = psel && penable && pwrite && pready;

  a_word_gives_result: assert property (@(posedge clk) disable iff (rst)
    acc |=> ##1 done)
    else $error("accepted word produced no result");

  a_no_stray_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc, 2))
    else $error("result without accepted word");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done high after reset");

  a_same_word_same_result: assert property (@(posedge clk) disable iff (rst)
    (acc && $past(acc) && !$past(rst) && !$past(cfg_we) && !cfg_we &&
     cmd == $past(cmd) && data_block == $past(data_block))
    |=> ##1 (result_block == $past(result_block)))
    else $error("identical words gave different results");

endmodule

bind simplified_aes_cipher saes_checker u_saes_checker (
  .clk          (clk),
  .rst          (rst),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .pready       (pready),
  .start        (start),
  .busy         (busy),
  .cmd          (cmd),
  .data_block   (data_block),
  .done         (done),
  .result_block (result_block)
);
